// ===== sv/vrp_pkg.sv =====
// ----------------------------------------------------------------------------
// vrp_pkg
// Shared types and codes of the video register port: channel payloads,
// opcodes, register numbers and the command passed from front to back.
// ----------------------------------------------------------------------------
package vrp_pkg;

  localparam int OBJECT_BYTES    = 256;
  localparam int NAME_PAGE_BYTES = 1024;
  localparam int PALETTE_ENTRIES = 32;
  localparam int OBJ_AW          = $clog2(OBJECT_BYTES);
  localparam int NAME_AW         = $clog2(2 * NAME_PAGE_BYTES);
  localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
  localparam int PAT_AW          = 13;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);

  localparam logic [3:0]  NTMAP_RESET   = 4'd12;
  localparam logic [13:0] PALETTE_BASE  = 14'h3F00;
  localparam logic [13:0] NAME_BASE     = 14'h2000;
  localparam logic [7:0]  PAL_MASK_GREY = 8'h30;
  localparam logic [7:0]  PAL_MASK_FULL = 8'h3F;

  localparam logic [2:0] OP_READ      = 3'd0;
  localparam logic [2:0] OP_WRITE     = 3'd1;
  localparam logic [2:0] OP_VBLANK    = 3'd2;
  localparam logic [2:0] OP_NMI_CHECK = 3'd3;
  localparam logic [2:0] OP_PRERENDER = 3'd4;

  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_MASK   = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_OAMADR = 3'd3;
  localparam logic [2:0] REG_OAMDAT = 3'd4;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_ADDR   = 3'd6;
  localparam logic [2:0] REG_DATA   = 3'd7;

  typedef struct packed {
    logic [2:0] opcode;
    logic [2:0] reg_select;
    logic [7:0] write_data;
    logic [7:0] pattern_read_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        nmi_request;
    logic        pattern_access;
    logic [12:0] pattern_address;
    logic        pattern_write;
    logic [7:0]  pattern_write_data;
  } out_item_t;

  typedef enum logic [3:0] {
    K_NONE,
    K_STATUS,
    K_NMI,
    K_OAM_RD,
    K_OAM_WR,
    K_PAL_RD,
    K_PAL_WR,
    K_NAME_RD,
    K_NAME_WR,
    K_PAT_RD,
    K_PAT_WR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [PAT_AW-1:0] addr;
    logic [7:0]        data;
    logic              grey;
    logic              vblank;
    logic              nmi;
  } cmd_t;

endpackage

// ===== sv/vrp_front.sv =====
// ----------------------------------------------------------------------------
// vrp_front
// Accepts CPU accesses and timing events, updates the scalar registers and
// turns each item into a command for the memory back end.
// ----------------------------------------------------------------------------
module vrp_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  vrp_pkg::in_item_t in_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [3:0]      cfg_data,
  input  logic            q_full,
  output logic            q_push,
  output vrp_pkg::cmd_t   q_cmd
);
  import vrp_pkg::*;

  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic        vblank_r, vblank_nxt;
  logic [7:0]  oam_addr_r, oam_addr_nxt;
  logic        toggle_r, toggle_nxt;
  logic [2:0]  fine_x_r, fine_x_nxt;
  logic [14:0] temp_r, temp_nxt;
  logic [15:0] vaddr_r, vaddr_nxt;
  logic [3:0]  ntmap_r;
  logic        accept;
  logic        wr;
  logic [13:0] va;
  logic [4:0]  pal_idx;
  logic [7:0]  d;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign q_push    = accept;
  assign wr        = (in_data.opcode == OP_WRITE);
  assign d         = in_data.write_data;
  assign va        = vaddr_r[13:0];

  always_comb begin
    pal_idx = va[4:0];
    if (pal_idx[1:0] == 2'b00) begin
      pal_idx[4] = 1'b0;
    end
  end

  always_comb begin
    ctrl_nxt     = ctrl_r;
    mask_nxt     = mask_r;
    vblank_nxt   = vblank_r;
    oam_addr_nxt = oam_addr_r;
    toggle_nxt   = toggle_r;
    fine_x_nxt   = fine_x_r;
    temp_nxt     = temp_r;
    vaddr_nxt    = vaddr_r;
    q_cmd        = '0;
    q_cmd.kind   = K_NONE;
    if (accept) begin
      unique case (in_data.opcode)
        OP_VBLANK: begin
          vblank_nxt = 1'b1;
        end
        OP_NMI_CHECK: begin
          q_cmd.kind = K_NMI;
          q_cmd.nmi  = ctrl_r[7];
        end
        OP_PRERENDER: begin
          vblank_nxt = 1'b0;
        end
        OP_READ, OP_WRITE: begin
          unique case (in_data.reg_select)
            REG_CTRL: begin
              if (wr) begin
                ctrl_nxt        = d;
                temp_nxt[11:10] = d[1:0];
              end
            end
            REG_MASK: begin
              if (wr) begin
                mask_nxt = d;
              end
            end
            REG_STATUS: begin
              if (!wr) begin
                q_cmd.kind   = K_STATUS;
                q_cmd.vblank = vblank_r;
                vblank_nxt   = 1'b0;
                toggle_nxt   = 1'b0;
              end
            end
            REG_OAMADR: begin
              if (wr) begin
                oam_addr_nxt = d;
              end
            end
            REG_OAMDAT: begin
              q_cmd.addr = PAT_AW'(oam_addr_r);
              q_cmd.data = d;
              if (wr) begin
                q_cmd.kind   = K_OAM_WR;
                oam_addr_nxt = oam_addr_r + 8'd1;
              end else begin
                q_cmd.kind = K_OAM_RD;
              end
            end
            REG_SCROLL: begin
              if (wr) begin
                if (!toggle_r) begin
                  fine_x_nxt    = d[2:0];
                  temp_nxt[4:0] = d[7:3];
                end else begin
                  temp_nxt[14:12] = d[2:0];
                  temp_nxt[9:5]   = d[7:3];
                end
                toggle_nxt = !toggle_r;
              end
            end
            REG_ADDR: begin
              if (wr) begin
                if (!toggle_r) begin
                  temp_nxt[14]   = 1'b0;
                  temp_nxt[13:8] = d[5:0];
                end else begin
                  temp_nxt[7:0] = d;
                  vaddr_nxt     = {1'b0, temp_r[14:8], d};
                end
                toggle_nxt = !toggle_r;
              end
            end
            REG_DATA: begin
              q_cmd.grey = mask_r[0];
              if (va >= PALETTE_BASE) begin
                q_cmd.kind = wr ? K_PAL_WR : K_PAL_RD;
                q_cmd.addr = PAT_AW'(pal_idx);
                q_cmd.data = d;
              end else if (va >= NAME_BASE) begin
                q_cmd.kind = wr ? K_NAME_WR : K_NAME_RD;
                q_cmd.addr = PAT_AW'({ntmap_r[va[11:10]], va[9:0]});
                q_cmd.data = d;
              end else begin
                q_cmd.kind = wr ? K_PAT_WR : K_PAT_RD;
                q_cmd.addr = va[12:0];
                q_cmd.data = wr ? d : in_data.pattern_read_data;
              end
              vaddr_nxt = vaddr_r + (ctrl_r[2] ? 16'd32 : 16'd1);
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r     <= '0;
      mask_r     <= '0;
      vblank_r   <= 1'b0;
      oam_addr_r <= '0;
      toggle_r   <= 1'b0;
      fine_x_r   <= '0;
      temp_r     <= '0;
      vaddr_r    <= '0;
      ntmap_r    <= NTMAP_RESET;
    end else begin
      ctrl_r     <= ctrl_nxt;
      mask_r     <= mask_nxt;
      vblank_r   <= vblank_nxt;
      oam_addr_r <= oam_addr_nxt;
      toggle_r   <= toggle_nxt;
      fine_x_r   <= fine_x_nxt;
      temp_r     <= temp_nxt;
      vaddr_r    <= vaddr_nxt;
      if (cfg_valid && cfg_ready) begin
        ntmap_r <= cfg_data;
      end
    end
  end

endmodule

// ===== sv/vrp_queue.sv =====
// ----------------------------------------------------------------------------
// vrp_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module vrp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  vrp_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output vrp_pkg::cmd_t head_cmd
);
  import vrp_pkg::*;

  cmd_t                entry_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_AW:0]   count_r;

  assign full     = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + (QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (QUEUE_AW+1)'(1);
      end
    end
  end

endmodule

// ===== sv/vrp_back.sv =====
// ----------------------------------------------------------------------------
// vrp_back
// Carries out queued commands: object, palette and name memories, the
// buffered read byte and the result register.
// ----------------------------------------------------------------------------
module vrp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  vrp_pkg::cmd_t      q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output vrp_pkg::out_item_t out_data
);
  import vrp_pkg::*;

  typedef enum logic [1:0] {
    BK_FETCH = 2'b01,
    BK_WAIT  = 2'b10
  } bk_state_t;

  bk_state_t  st_r, st_nxt;
  cmd_t       cur_r, cur_nxt;
  logic [7:0] rb_r, rb_nxt;
  out_item_t  out_r, out_nxt;
  logic       ov_r, ov_nxt;
  logic       slot_free;
  out_item_t  res;
  logic [7:0] pal_got;

  logic [7:0] obj_mem  [OBJECT_BYTES];
  logic [7:0] pal_mem  [PALETTE_ENTRIES];
  logic [7:0] name_mem [2 * NAME_PAGE_BYTES];
  logic [7:0] obj_rd_r, pal_rd_r, name_rd_r;

  assign slot_free = !ov_r || out_ready;
  assign out_valid = ov_r;
  assign out_data  = out_r;
  assign pal_got   = pal_rd_r & (cur_r.grey ? PAL_MASK_GREY : PAL_MASK_FULL);

  // memories
  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_head.kind == K_OAM_WR) begin
        obj_mem[q_head.addr[OBJ_AW-1:0]] <= q_head.data;
      end
      obj_rd_r <= obj_mem[q_head.addr[OBJ_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_head.kind == K_PAL_WR) begin
        pal_mem[q_head.addr[PAL_AW-1:0]] <= q_head.data;
      end
      pal_rd_r <= pal_mem[q_head.addr[PAL_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_head.kind == K_NAME_WR) begin
        name_mem[q_head.addr[NAME_AW-1:0]] <= q_head.data;
      end
      name_rd_r <= name_mem[q_head.addr[NAME_AW-1:0]];
    end
  end

  always_comb begin
    st_nxt  = st_r;
    cur_nxt = cur_r;
    rb_nxt  = rb_r;
    out_nxt = out_r;
    ov_nxt  = ov_r && !out_ready;
    q_pop   = 1'b0;
    res     = '0;
    unique case (st_r)
      BK_FETCH: begin
        if (!q_empty && slot_free) begin
          q_pop   = 1'b1;
          cur_nxt = q_head;
          unique case (q_head.kind)
            K_OAM_RD, K_PAL_RD, K_NAME_RD: begin
              st_nxt = BK_WAIT;
            end
            K_STATUS: begin
              res.read_data = {q_head.vblank, 2'b00, rb_r[4:0]};
            end
            K_NMI: begin
              res.nmi_request = q_head.nmi;
            end
            K_PAT_RD: begin
              res.read_data       = rb_r;
              res.pattern_access  = 1'b1;
              res.pattern_address = q_head.addr;
              rb_nxt              = q_head.data;
            end
            K_PAT_WR: begin
              res.pattern_access     = 1'b1;
              res.pattern_address    = q_head.addr;
              res.pattern_write      = 1'b1;
              res.pattern_write_data = q_head.data;
            end
            default: begin
            end
          endcase
          if (st_nxt == BK_FETCH) begin
            out_nxt = res;
            ov_nxt  = 1'b1;
          end
        end
      end
      BK_WAIT: begin
        unique case (cur_r.kind)
          K_OAM_RD: begin
            res.read_data = obj_rd_r;
          end
          K_PAL_RD: begin
            res.read_data = pal_got;
            rb_nxt        = pal_got;
          end
          default: begin
            res.read_data = rb_r;
            rb_nxt        = name_rd_r;
          end
        endcase
        out_nxt = res;
        ov_nxt  = 1'b1;
        st_nxt  = BK_FETCH;
      end
      default: begin
        st_nxt = BK_FETCH;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_FETCH;
      rb_r <= '0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      rb_r <= rb_nxt;
      ov_r <= ov_nxt;
    end
  end

endmodule

// ===== sv/video_register_port_top.sv =====
// ----------------------------------------------------------------------------
// video_register_port_top
// CPU register file of a tile-based video unit with a decoupled back end.
// ----------------------------------------------------------------------------
// in_*  : one CPU access or timing event per transfer (valid/ready)
// out_* : exactly one result per input transfer, in order (valid/ready)
// cfg_* : name page map write, taken every cycle; the user writes it only
// while the block idles, which the block itself does not enforce
// the front updates all scalar registers in the transfer cycle and queues a
// command; the back end executes commands from a two-entry queue
// results pass the queue and the result register; object, palette and name
// reads also pass the registered memory read port and a wait state, in which
// the back end takes no new command; else 1 item per cycle while out_ready
// reset: CPU registers cleared, name page map set to 12, memories not cleared
// receiver stall: the result register holds, the queue fills, then in_ready
// drops until the back end moves again
// ----------------------------------------------------------------------------
module video_register_port_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  vrp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output vrp_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_data
);
  import vrp_pkg::*;

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  cmd_t q_cmd;
  cmd_t q_head;

  vrp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  vrp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_cmd (q_head)
  );

  vrp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
